>>> design/delta_coastline_segment_decoder_assert.svh
// assertion macros used by the decoder top module
`ifndef DELTA_COASTLINE_SEGMENT_DECODER_ASSERT_SVH
`define DELTA_COASTLINE_SEGMENT_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");

// next-cycle implication, sampled on clk, off during reset
`define DCSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder sequence check failed");

`endif

>>> design/dcsd_pkg.sv
package dcsd_pkg;

  localparam logic [19:0] UPD_RESET   = 20'd3600;
  localparam logic [31:0] OFFSET_BIAS = 32'd262144;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LATOFF = 2'd1,
    PH_LONOFF = 2'd2,
    PH_DELTA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] data_word;
    logic [7:0]  cell_lat;
    logic [9:0]  cell_lon;
    logic        cell_last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_lat;
    logic signed [31:0] point_lon;
    logic [5:0]         point_rank;
    logic               line_start;
  } out_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  points_left;
    logic        is_cont;
    logic [5:0]  seg_rank;
    logic [2:0]  lon_off_high;
    logic [19:0] lat_off_pend;
    logic [31:0] lat_accum;
    logic [31:0] lon_accum;
  } seg_state_t;

endpackage

>>> design/dcsd_step.sv
module dcsd_step (
  input  dcsd_pkg::seg_state_t cur,
  input  dcsd_pkg::in_word_t   in_word,
  input  logic [19:0]          upd,
  output dcsd_pkg::seg_state_t nxt,
  output logic                 emit,
  output dcsd_pkg::out_word_t  res
);
  import dcsd_pkg::*;

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [27:0] lat_prod;
  logic [29:0] lon_prod;
  logic [31:0] lat_add;
  logic [31:0] lon_add;
  logic        line_start;

  assign b0       = in_word.data_word[15:8];
  assign b1       = in_word.data_word[7:0];
  assign lat_prod = in_word.cell_lat * upd;
  assign lon_prod = in_word.cell_lon * upd;

  always_comb begin
    nxt        = cur;
    emit       = 1'b0;
    line_start = 1'b0;
    lat_add    = {12'd0, cur.lat_off_pend};
    lon_add    = {13'd0, cur.lon_off_high, in_word.data_word};
    case (cur.phase)
      PH_HEADER: begin
        nxt.points_left = {1'b0, b0[6:0], b1[7:6]};
        nxt.is_cont     = b0[7];
        if (b0[7]) begin
          nxt.lat_off_pend = {1'b0, b1[5:3], 16'd0};
          nxt.lon_off_high = b1[2:0];
        end else begin
          nxt.seg_rank     = b1[5:0];
          nxt.lat_off_pend = 20'd0;
          nxt.lon_off_high = 3'd0;
          nxt.lat_accum    = {4'd0, lat_prod};
          nxt.lon_accum    = {2'd0, lon_prod};
        end
        nxt.phase = PH_LATOFF;
      end
      PH_LATOFF: begin
        nxt.lat_off_pend = cur.lat_off_pend + {4'd0, in_word.data_word};
        nxt.phase        = PH_LONOFF;
      end
      PH_LONOFF: begin
        if (cur.is_cont) begin
          lat_add = {12'd0, cur.lat_off_pend} - OFFSET_BIAS;
          lon_add = {13'd0, cur.lon_off_high, in_word.data_word} - OFFSET_BIAS;
        end
        nxt.lat_accum = cur.lat_accum + lat_add;
        nxt.lon_accum = cur.lon_accum + lon_add;
        emit          = 1'b1;
        line_start    = !cur.is_cont;
        nxt.phase     = (cur.points_left == 10'd0) ? PH_HEADER : PH_DELTA;
      end
      PH_DELTA: begin
        // each byte less 128, sign extended
        nxt.lat_accum   = cur.lat_accum + {{24{~b0[7]}}, ~b0[7], b0[6:0]};
        nxt.lon_accum   = cur.lon_accum + {{24{~b1[7]}}, ~b1[7], b1[6:0]};
        emit            = 1'b1;
        nxt.points_left = cur.points_left - 10'd1;
        if (cur.points_left == 10'd1) begin
          nxt.phase = PH_HEADER;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    if (in_word.cell_last) begin
      nxt.phase       = PH_HEADER;
      nxt.points_left = 10'd0;
    end
  end

  assign res.point_lat  = nxt.lat_accum;
  assign res.point_lon  = nxt.lon_accum;
  assign res.point_rank = nxt.seg_rank;
  assign res.line_start = line_start;

endmodule

>>> design/delta_coastline_segment_decoder.sv
// channel   dir  handshake              payload
// in_       in   in_valid / in_ready    in_data  (dcsd_pkg::in_word_t)
// out_      out  out_valid / out_ready  out_data (dcsd_pkg::out_word_t)
// cfg_      in   cfg_valid / cfg_ready  cfg_data (units per degree, 20 bits)
//
// one word per cycle sustained while out_ready holds; a point goes through the input register, then the result register
// the cell multiply and accumulator add sit between the input and result registers
// rst_n is synchronous; reset gives 3600 units per degree and expects a header
// a stalled result holds in the result register while one more word waits in
// the input register; in_ready drops only when both are full
`include "delta_coastline_segment_decoder_assert.svh"

module delta_coastline_segment_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcsd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dcsd_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [19:0]         cfg_data
);
  import dcsd_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  in_word_t   s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_word_t  out_data_r;
  seg_state_t st_r;
  seg_state_t st_nxt;
  logic [19:0] upd_r;
  logic       advance;
  logic       emit;
  out_word_t  res;

  dcsd_step u_step (
    .cur     (st_r),
    .in_word (s1_data_r),
    .upd     (upd_r),
    .nxt     (st_nxt),
    .emit    (emit),
    .res     (res)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      upd_r       <= UPD_RESET;
      st_r        <= '{phase: PH_HEADER, default: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        upd_r <= cfg_data;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

  `DCSD_ASSERT_NEXT(a_emit_fills_out, advance && emit, out_valid_r)
  `DCSD_ASSERT_NEXT(a_cell_end_resyncs, advance && s1_data_r.cell_last,
                    st_r.phase == PH_HEADER && st_r.points_left == 10'd0)
  `DCSD_ASSERT_NEXT(a_last_delta_ends,
                    advance && st_r.phase == PH_DELTA && st_r.points_left == 10'd1,
                    st_r.phase == PH_HEADER)
  `DCSD_ASSERT_NEXT(a_held_word_kept, s1_valid_r && !advance, s1_valid_r)
  `DCSD_ASSERT_NOW(a_no_emit_on_offsets,
                   st_r.phase == PH_HEADER || st_r.phase == PH_LATOFF, !emit)

endmodule
